// ===== rtl/ihex_pkg.sv =====
// Shared types, codes and the hex digit decoder for the Intel HEX record parser.
`default_nettype none

package ihex_pkg;

    // Result status codes
    localparam logic [1:0] STATUS_DATA  = 2'd0;
    localparam logic [1:0] STATUS_DONE  = 2'd1;
    localparam logic [1:0] STATUS_ERROR = 2'd2;

    // Parser finish codes
    localparam logic [1:0] FIN_RUN   = 2'd0;
    localparam logic [1:0] FIN_DONE  = 2'd1;
    localparam logic [1:0] FIN_ERROR = 2'd2;

    // Characters of interest
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_F  = 8'h46;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_F  = 8'h66;

    // Record overhead in characters: colon, count, address, type, checksum
    localparam logic [9:0] LINE_OVERHEAD = 10'd11;

    // Record types
    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_END  = 8'h01;

    // Field positions (byte index within the record)
    localparam logic [8:0] BYTE_COUNT   = 9'd0;
    localparam logic [8:0] BYTE_ADDR_HI = 9'd1;
    localparam logic [8:0] BYTE_ADDR_LO = 9'd2;
    localparam logic [8:0] BYTE_TYPE    = 9'd3;
    localparam logic [8:0] BYTE_DATA    = 9'd4;

    typedef struct packed {
        logic [9:0]  char_position;
        logic [3:0]  high_nibble;
        logic [7:0]  byte_count;
        logic [15:0] record_address;
        logic [7:0]  record_type;
        logic [7:0]  running_checksum;
        logic        saw_cr;
        logic        have_start;
        logic [15:0] load_start;
        logic [16:0] loaded_length;
        logic [1:0]  finish_state;
    } parse_state_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  data_byte;
        logic [15:0] image_offset;
        logic [15:0] start_address;
        logic [16:0] image_length;
    } result_t;

    // Decode one ASCII hex digit: bit 4 flags a valid digit, bits 3:0 the value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] diff;
        begin
            diff = 8'd0;
            if (c >= CHAR_ZERO && c <= CHAR_NINE)
            begin
                diff = c - CHAR_ZERO;
                hex_digit = {1'b1, diff[3:0]};
            end
            else if (c >= CHAR_UP_A && c <= CHAR_UP_F)
            begin
                diff = c - CHAR_UP_A + 8'd10;
                hex_digit = {1'b1, diff[3:0]};
            end
            else if (c >= CHAR_LO_A && c <= CHAR_LO_F)
            begin
                diff = c - CHAR_LO_A + 8'd10;
                hex_digit = {1'b1, diff[3:0]};
            end
            else
            begin
                hex_digit = 5'd0;
            end
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ihex_step.sv =====
// Per-character parsing logic: next parser state and the result for one request.
`default_nettype none

module ihex_step (
    input  wire ihex_pkg::parse_state_t cur,
    input  wire logic [7:0]             ch,
    input  wire logic                   stream_end,
    output ihex_pkg::parse_state_t      nxt,
    output logic                        res_valid,
    output ihex_pkg::result_t           res
);

    logic [9:0]  line_limit;
    logic [9:0]  char_k;
    logic [8:0]  byte_idx;
    logic [8:0]  data_end;
    logic [4:0]  digit;
    logic [7:0]  value;
    logic [17:0] image_end;
    logic        err;
    logic        done;
    logic        emit;

    // Derived values from the current state and character
    assign line_limit = {1'b0, cur.byte_count, 1'b0} + ihex_pkg::LINE_OVERHEAD;
    assign char_k     = cur.char_position - 10'd1;
    assign byte_idx   = char_k[9:1];
    assign data_end   = ihex_pkg::BYTE_DATA + {1'b0, cur.byte_count};
    assign digit      = ihex_pkg::hex_digit(ch);
    assign value      = {cur.high_nibble, digit[3:0]};
    assign image_end  = {2'b00, cur.load_start} + {1'b0, cur.loaded_length};

    // Advance the parser by one character
    always_comb
    begin
        nxt  = cur;
        err  = 1'b0;
        done = 1'b0;
        emit = 1'b0;

        priority if (cur.finish_state != ihex_pkg::FIN_RUN)
        begin
            // finished: drop everything
        end
        else if (stream_end)
        begin
            err = 1'b1;
        end
        else if (ch == ihex_pkg::CHAR_LF)
        begin
            if (cur.char_position < 10'd3 || cur.char_position != line_limit)
            begin
                err = 1'b1;
            end
            else if (cur.running_checksum != 8'd0)
            begin
                err = 1'b1;
            end
            else
            begin
                nxt.char_position    = 10'd0;
                nxt.high_nibble      = 4'd0;
                nxt.running_checksum = 8'd0;
                nxt.saw_cr           = 1'b0;
                if (cur.record_type == ihex_pkg::REC_END)
                begin
                    done             = 1'b1;
                    nxt.finish_state = ihex_pkg::FIN_DONE;
                end
            end
        end
        else if (cur.saw_cr)
        begin
            err = 1'b1;
        end
        else if (ch == ihex_pkg::CHAR_CR)
        begin
            if (cur.char_position == 10'd0)
                err = 1'b1;
            else
                nxt.saw_cr = 1'b1;
        end
        else if (cur.char_position == 10'd0)
        begin
            if (ch != ihex_pkg::CHAR_COLON)
                err = 1'b1;
            else
                nxt.char_position = 10'd1;
        end
        else if (cur.char_position >= 10'd3 && cur.char_position >= line_limit)
        begin
            err = 1'b1;
        end
        else if (!digit[4])
        begin
            err = 1'b1;
        end
        else
        begin
            nxt.char_position = cur.char_position + 10'd1;
            if (!char_k[0])
            begin
                nxt.high_nibble = digit[3:0];
            end
            else
            begin
                nxt.running_checksum = cur.running_checksum + value;
                priority if (byte_idx == ihex_pkg::BYTE_COUNT)
                begin
                    nxt.byte_count = value;
                end
                else if (byte_idx == ihex_pkg::BYTE_ADDR_HI)
                begin
                    nxt.record_address = {value, 8'd0};
                end
                else if (byte_idx == ihex_pkg::BYTE_ADDR_LO)
                begin
                    nxt.record_address = {cur.record_address[15:8],
                                          cur.record_address[7:0] | value};
                end
                else if (byte_idx == ihex_pkg::BYTE_TYPE)
                begin
                    nxt.record_type = value;
                    if (value > ihex_pkg::REC_END)
                    begin
                        err = 1'b1;
                    end
                    else if (value == ihex_pkg::REC_DATA)
                    begin
                        // records must follow on from the image so far
                        if (cur.have_start)
                        begin
                            if (image_end != {2'b00, cur.record_address})
                                err = 1'b1;
                        end
                        else
                        begin
                            nxt.have_start    = 1'b1;
                            nxt.load_start    = cur.record_address;
                            nxt.loaded_length = 17'd0;
                        end
                    end
                end
                else if (byte_idx < data_end && cur.record_type == ihex_pkg::REC_DATA)
                begin
                    if (image_end > 18'h0FFFF)
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        emit              = 1'b1;
                        nxt.loaded_length = cur.loaded_length + 17'd1;
                    end
                end
                else
                begin
                    // checksum or end record payload: sum only
                end
            end
        end

        if (err)
            nxt.finish_state = ihex_pkg::FIN_ERROR;
    end

    // Form the result
    always_comb
    begin
        res_valid         = err | done | emit;
        res.status        = ihex_pkg::STATUS_DATA;
        res.data_byte     = 8'd0;
        res.image_offset  = 16'd0;
        res.start_address = nxt.load_start;
        res.image_length  = nxt.loaded_length;
        priority if (err)
        begin
            res.status = ihex_pkg::STATUS_ERROR;
        end
        else if (done)
        begin
            res.status = ihex_pkg::STATUS_DONE;
        end
        else
        begin
            res.data_byte    = value;
            res.image_offset = cur.loaded_length[15:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/intel_hex_record_parser.sv =====
// Top level of the Intel HEX record parser: input register, parse logic, result register.
//
//  Channel   Signals                                         Dir   Handshake
//  input     ch[7:0], stream_end                             in    in_valid / in_ready
//  result    status[1:0], data_byte[7:0], image_offset[15:0],
//            start_address[15:0], image_length[16:0]         out   out_valid / out_ready
//
// One character per cycle while no result waits in the result register: a request is
// taken into the input register, then parsed and its result, if any, written to the
// result register, from which it reaches the output ports.
// Reset clears the parser state and the valid flags of both register stages.
// A waiting result that is not taken stalls parsing, and intake once the input register
// is full; in_ready stays high while that register is empty or its request can move on.
`default_nettype none

module intel_hex_record_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  ch,
    input  wire logic        stream_end,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [7:0]       data_byte,
    output logic [15:0]      image_offset,
    output logic [15:0]      start_address,
    output logic [16:0]      image_length
);

    logic                   in_full_reg;
    logic [7:0]             ch_reg;
    logic                   end_reg;
    ihex_pkg::parse_state_t state_reg;
    ihex_pkg::parse_state_t state_next;
    logic                   res_valid;
    ihex_pkg::result_t      res;
    logic                   out_valid_reg;
    ihex_pkg::result_t      res_reg;
    logic                   advance;

    // Move the held request on when the result register is free or draining
    assign advance  = in_full_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_full_reg || advance;

    ihex_step u_step (
        .cur        (state_reg),
        .ch         (ch_reg),
        .stream_end (end_reg),
        .nxt        (state_next),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ch_reg  <= ch;
            end_reg <= stream_end;
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register: load on a new result, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_valid;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = res_reg.status;
    assign data_byte     = res_reg.data_byte;
    assign image_offset  = res_reg.image_offset;
    assign start_address = res_reg.start_address;
    assign image_length  = res_reg.image_length;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Testbench for the Intel HEX record parser: stream builder, predictor, driver and monitor.
`timescale 1ns / 1ps

module tb_top;

    // Ways in which the character stream is brought to its end
    typedef enum int {
        ENDING_COMPLETE,
        ENDING_STREAM_CUT,
        ENDING_BAD_SUM,
        ENDING_BAD_DIGIT,
        ENDING_BAD_TYPE,
        ENDING_ADDR_GAP,
        ENDING_LINE_LONG,
        ENDING_LINE_SHORT,
        ENDING_EMPTY_LINE,
        ENDING_COLON_ONLY,
        ENDING_CR_AT_START,
        ENDING_CR_TWICE,
        ENDING_CR_THEN_CHAR,
        ENDING_NO_COLON,
        ENDING_ADDR_TOP,
        ENDING_COUNT
    } stream_ending_t;

    typedef struct {
        logic [7:0] ch_value;
        logic       end_mark;
    } text_char_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  ch = 8'h00;
    logic        stream_end = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [7:0]  data_byte;
    logic [15:0] image_offset;
    logic [15:0] start_address;
    logic [16:0] image_length;

    // Stream under construction and requests waiting for the driver
    text_char_t  hex_text[$];
    logic [7:0]  line_bytes[$];
    logic [7:0]  line_text[$];
    int          record_sizes[$];
    int          total_chars = 0;
    int          chars_accepted = 0;
    int          start_addr = 0;
    string       ending_label = "";

    // Parser state held by the predictor
    logic [9:0]  line_pos = '0;
    logic [3:0]  upper_nibble = '0;
    logic [7:0]  rec_count = '0;
    logic [15:0] rec_addr = '0;
    logic [7:0]  rec_type = '0;
    logic [7:0]  line_sum = '0;
    logic        cr_seen = 1'b0;
    logic        start_known = 1'b0;
    logic [15:0] image_start = '0;
    logic [16:0] image_bytes = '0;
    logic [1:0]  parse_outcome = ihex_pkg::FIN_RUN;
    ihex_pkg::result_t parser_reports[$];

    int          mismatches = 0;
    int          reports_checked = 0;
    int          bytes_checked = 0;
    int          send_gap = 0;
    int          recv_gap = 0;
    text_char_t  outgoing;
    ihex_pkg::result_t wanted;

    intel_hex_record_parser DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .ch            (ch),
        .stream_end    (stream_end),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .data_byte     (data_byte),
        .image_offset  (image_offset),
        .start_address (start_address),
        .image_length  (image_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Value of one ASCII hex digit, -1 for anything else
    function automatic int nibble_of(input logic [7:0] c);
        begin
            if (c >= "0" && c <= "9")
                return int'(c) - int'("0");
            if (c >= "A" && c <= "F")
                return int'(c) - int'("A") + 10;
            if (c >= "a" && c <= "f")
                return int'(c) - int'("a") + 10;
            return -1;
        end
    endfunction

    // Hex digit for a nibble, letters in either case
    function automatic logic [7:0] digit_char(input logic [3:0] n);
        begin
            if (n < 4'd10)
                return ihex_pkg::CHAR_ZERO + {4'd0, n};
            return ($urandom_range(0, 1) ? ihex_pkg::CHAR_UP_A : ihex_pkg::CHAR_LO_A)
                   + {4'd0, n} - 8'd10;
        end
    endfunction

    // Random character that is neither a line ending nor, as asked, a digit or a colon
    function automatic logic [7:0] stray_char(input bit digits_ok);
        logic [7:0] c;
        begin
            c = ihex_pkg::CHAR_LF;
            while (c == ihex_pkg::CHAR_LF || c == ihex_pkg::CHAR_CR
                   || (digits_ok ? (c == ihex_pkg::CHAR_COLON) : (nibble_of(c) >= 0)))
                c = 8'($urandom_range(0, 255));
            return c;
        end
    endfunction

    function automatic void post_report(input logic [1:0] st, input logic [7:0] value,
                                        input logic [15:0] offset);
        ihex_pkg::result_t r;
        begin
            r.status        = st;
            r.data_byte     = value;
            r.image_offset  = offset;
            r.start_address = image_start;
            r.image_length  = image_bytes;
            parser_reports.push_back(r);
        end
    endfunction

    function automatic void report_error();
        begin
            parse_outcome = ihex_pkg::FIN_ERROR;
            post_report(ihex_pkg::STATUS_ERROR, 8'h00, 16'h0000);
        end
    endfunction

    // Advance the parser by one accepted request and queue the report it causes
    function automatic void decode_char(input logic [7:0] c, input logic end_flag);
        logic [9:0]  line_len;
        logic [9:0]  k;
        logic [7:0]  value;
        logic [17:0] reach;
        logic [15:0] offset;
        int          digit;
        int          b;
        begin
            line_len = {1'b0, rec_count, 1'b0} + ihex_pkg::LINE_OVERHEAD;
            if (parse_outcome != ihex_pkg::FIN_RUN)
                return;
            if (end_flag)
            begin
                report_error();
                return;
            end
            // close the line: length and checksum
            if (c == ihex_pkg::CHAR_LF)
            begin
                if (line_pos < 10'd3 || line_pos != line_len || line_sum != 8'h00)
                    report_error();
                else
                begin
                    line_pos = '0;
                    upper_nibble = '0;
                    line_sum = '0;
                    cr_seen = 1'b0;
                    if (rec_type == ihex_pkg::REC_END)
                    begin
                        parse_outcome = ihex_pkg::FIN_DONE;
                        post_report(ihex_pkg::STATUS_DONE, 8'h00, 16'h0000);
                    end
                end
                return;
            end
            if (cr_seen)
            begin
                report_error();
                return;
            end
            if (c == ihex_pkg::CHAR_CR)
            begin
                if (line_pos == 10'd0)
                    report_error();
                else
                    cr_seen = 1'b1;
                return;
            end
            if (line_pos == 10'd0)
            begin
                if (c != ihex_pkg::CHAR_COLON)
                    report_error();
                else
                    line_pos = 10'd1;
                return;
            end
            digit = nibble_of(c);
            if ((line_pos >= 10'd3 && line_pos >= line_len) || digit < 0)
            begin
                report_error();
                return;
            end
            k = line_pos - 10'd1;
            line_pos = line_pos + 10'd1;
            if (!k[0])
            begin
                upper_nibble = digit[3:0];
                return;
            end
            value = {upper_nibble, digit[3:0]};
            line_sum = line_sum + value;
            b = int'(k >> 1);
            if (b == 0)
                rec_count = value;
            else if (b == 1)
                rec_addr = {value, 8'h00};
            else if (b == 2)
                rec_addr = rec_addr | {8'h00, value};
            else if (b == 3)
            begin
                rec_type = value;
                if (value > ihex_pkg::REC_END)
                    report_error();
                else if (value == ihex_pkg::REC_DATA)
                begin
                    if (start_known)
                    begin
                        if ({2'b00, image_start} + {1'b0, image_bytes} != {2'b00, rec_addr})
                            report_error();
                    end
                    else
                    begin
                        start_known = 1'b1;
                        image_start = rec_addr;
                        image_bytes = '0;
                    end
                end
            end
            else if (b < 4 + int'(rec_count) && rec_type == ihex_pkg::REC_DATA)
            begin
                reach = {2'b00, image_start} + {1'b0, image_bytes};
                if (reach > 18'h0FFFF)
                    report_error();
                else
                begin
                    offset = image_bytes[15:0];
                    image_bytes = image_bytes + 17'd1;
                    post_report(ihex_pkg::STATUS_DATA, value, offset);
                end
            end
        end
    endfunction

    // Make the last byte of the record the two's complement of the rest
    task automatic seal_checksum();
        logic [7:0] sum;
        begin
            sum = 8'h00;
            for (int i = 0; i < line_bytes.size() - 1; i++)
                sum = sum + line_bytes[i];
            line_bytes[line_bytes.size() - 1] = 8'h00 - sum;
        end
    endtask

    task automatic make_record(input int cnt, input logic [15:0] addr, input logic [7:0] rtype);
        begin
            line_bytes.delete();
            line_bytes.push_back(8'(cnt));
            line_bytes.push_back(addr[15:8]);
            line_bytes.push_back(addr[7:0]);
            line_bytes.push_back(rtype);
            repeat (cnt)
                line_bytes.push_back(8'($urandom_range(0, 255)));
            line_bytes.push_back(8'h00);
            seal_checksum();
        end
    endtask

    task automatic render_line(input bit with_cr);
        begin
            line_text.delete();
            line_text.push_back(ihex_pkg::CHAR_COLON);
            foreach (line_bytes[i])
            begin
                line_text.push_back(digit_char(line_bytes[i][7:4]));
                line_text.push_back(digit_char(line_bytes[i][3:0]));
            end
            if (with_cr)
                line_text.push_back(ihex_pkg::CHAR_CR);
            line_text.push_back(ihex_pkg::CHAR_LF);
        end
    endtask

    task automatic send_text();
        text_char_t t;
        begin
            foreach (line_text[i])
            begin
                t.ch_value = line_text[i];
                t.end_mark = 1'b0;
                hex_text.push_back(t);
            end
        end
    endtask

    // Idling is off in some stretches and in the closing part of the run
    function automatic bit idle_roll(input int progress, input int phase);
        begin
            if (progress + 150 >= total_chars)
                return 1'b0;
            unique case ((progress / 200 + phase) % 3)
                0:       return 1'b0;
                1:       return $urandom_range(0, 3) == 0;
                default: return $urandom_range(0, 15) == 0;
            endcase
        end
    endfunction

    task automatic compare_field(input string label, input logic [16:0] want,
                                 input logic [16:0] got);
        begin
            if (want !== got)
            begin
                mismatches++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, label, want, got);
            end
        end
    endtask

    // Driver: hold each request until taken, predict on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            ch         <= 8'h00;
            stream_end <= 1'b0;
            send_gap   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                decode_char(ch, stream_end);
                chars_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (hex_text.size() == 0)
                    in_valid <= 1'b0;
                else if (idle_roll(chars_accepted, 0))
                begin
                    send_gap <= $urandom_range(0, 11);
                    in_valid <= 1'b0;
                end
                else
                begin
                    outgoing   = hex_text.pop_front();
                    ch         <= outgoing.ch_value;
                    stream_end <= outgoing.end_mark;
                    in_valid   <= 1'b1;
                end
            end
        end
    end

    // Monitor: compare each report with the oldest prediction, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (parser_reports.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected report, expected none, %s %0d byte 0x%0h",
                             $time, "actual status", status, data_byte);
                end
                else
                begin
                    wanted = parser_reports.pop_front();
                    reports_checked++;
                    if (wanted.status == ihex_pkg::STATUS_DATA)
                        bytes_checked++;
                    compare_field("status", 17'(wanted.status), 17'(status));
                    compare_field("data_byte", 17'(wanted.data_byte), 17'(data_byte));
                    compare_field("image_offset", 17'(wanted.image_offset), 17'(image_offset));
                    compare_field("start_address", 17'(wanted.start_address),
                                  17'(start_address));
                    compare_field("image_length", wanted.image_length, image_length);
                end
            end
            if (recv_gap != 0)
            begin
                recv_gap  <= recv_gap - 1;
                out_ready <= 1'b0;
            end
            else if (idle_roll(chars_accepted, 1))
            begin
                recv_gap  <= $urandom_range(0, 11);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Give up on a hung run
    initial
    begin
        #2_000_000;
        $display("Timeout at %0t with %0d of %0d characters taken, %0d reports outstanding",
                 $time, chars_accepted, total_chars, parser_reports.size());
        $display("CHECK FAILED");
        $finish;
    end

    // Build the whole stream, release reset, then drain
    initial
    begin
        stream_ending_t ending;
        text_char_t     t;
        int             est_chars;
        int             c;
        int             image_total;
        int             addr_limit;
        int             next_addr;
        int             top_margin;
        int             fc;
        int             pos;

        // plan the data records: a short directed pair first, then random sizes
        record_sizes.push_back(2);
        record_sizes.push_back(0);
        est_chars = 29;
        while (est_chars < 1650)
        begin
            c = $urandom_range(0, 99);
            if (c < 8)
                c = 0;
            else if (c < 10)
                c = 255;
            else if (c < 20)
                c = $urandom_range(33, 254);
            else
                c = $urandom_range(1, 32);
            record_sizes.push_back(c);
            est_chars += 2 * c + 12;
        end
        if (record_sizes[record_sizes.size() - 1] == 0)
            record_sizes[record_sizes.size() - 1] = 1;
        image_total = 0;
        foreach (record_sizes[i])
            image_total += record_sizes[i];

        if ($urandom_range(0, 3) == 0)
            ending = ENDING_COMPLETE;
        else
            ending = stream_ending_t'($urandom_range(0, ENDING_COUNT - 1));

        // pick the load address: bottom, the highest the ending allows, or anywhere between
        top_margin = $urandom_range(1, 4);
        if (ending == ENDING_ADDR_TOP)
            start_addr = 32'h10000 - image_total - top_margin;
        else
        begin
            addr_limit = (ending == ENDING_COMPLETE) ? 32'h10000 - image_total
                                                     : 32'hFFFF - image_total - 8;
            unique case ($urandom_range(0, 3))
                0:       start_addr = 0;
                1:       start_addr = addr_limit;
                default: start_addr = $urandom_range(0, addr_limit);
            endcase
        end

        // well-formed data records, with random content but for the first
        next_addr = start_addr;
        foreach (record_sizes[i])
        begin
            make_record(record_sizes[i], 16'(next_addr), ihex_pkg::REC_DATA);
            if (i == 0)
            begin
                line_bytes[4] = 8'hFF;
                line_bytes[5] = 8'h00;
                seal_checksum();
            end
            render_line(i == 0 ? 1'b1 : 1'($urandom_range(0, 1)));
            send_text();
            next_addr += record_sizes[i];
        end

        // final line: a proper end record or one kind of fault
        fc = $urandom_range(0, 8);
        make_record(fc, 16'(next_addr), ihex_pkg::REC_DATA);
        render_line(1'($urandom_range(0, 1)));
        unique case (ending)
            ENDING_COMPLETE:
            begin
                ending_label = "an end record";
                make_record($urandom_range(0, 1) ? 0 : $urandom_range(1, 4),
                            $urandom_range(0, 1) ? 16'h0000 : 16'($urandom_range(0, 65535)),
                            ihex_pkg::REC_END);
                render_line(1'($urandom_range(0, 1)));
            end
            ENDING_STREAM_CUT:
            begin
                ending_label = "end of stream before an end record";
                pos = $urandom_range(0, line_text.size() - 1);
                while (line_text.size() > pos)
                    void'(line_text.pop_back());
            end
            ENDING_BAD_SUM:
            begin
                ending_label = "a bad checksum";
                line_bytes[line_bytes.size() - 1] ^= 8'($urandom_range(1, 255));
                render_line(1'($urandom_range(0, 1)));
            end
            ENDING_BAD_DIGIT:
            begin
                ending_label = "a character that is not a hex digit";
                line_text[$urandom_range(1, 2 * line_bytes.size())] = stray_char(1'b0);
            end
            ENDING_BAD_TYPE:
            begin
                ending_label = "an unknown record type";
                make_record(fc, 16'(next_addr), 8'($urandom_range(2, 255)));
                render_line(1'($urandom_range(0, 1)));
            end
            ENDING_ADDR_GAP:
            begin
                ending_label = "a gap in the data addresses";
                make_record(fc, 16'(next_addr) ^ 16'($urandom_range(1, 65535)),
                            ihex_pkg::REC_DATA);
                render_line(1'($urandom_range(0, 1)));
            end
            ENDING_LINE_LONG:
            begin
                ending_label = "a line that is too long";
                line_text.insert(2 * line_bytes.size() + 1,
                                 digit_char(4'($urandom_range(0, 15))));
            end
            ENDING_LINE_SHORT:
            begin
                ending_label = "a line that is too short";
                line_text.delete(2 * line_bytes.size());
            end
            ENDING_EMPTY_LINE:
            begin
                ending_label = "an empty line";
                line_text.delete();
                line_text.push_back(ihex_pkg::CHAR_LF);
            end
            ENDING_COLON_ONLY:
            begin
                ending_label = "a line cut after its colon";
                line_text.delete();
                line_text.push_back(ihex_pkg::CHAR_COLON);
                if ($urandom_range(0, 1))
                    line_text.push_back(digit_char(4'($urandom_range(0, 15))));
                line_text.push_back(ihex_pkg::CHAR_LF);
            end
            ENDING_CR_AT_START:
            begin
                ending_label = "a carriage return at line start";
                line_text.delete();
                line_text.push_back(ihex_pkg::CHAR_CR);
                line_text.push_back(ihex_pkg::CHAR_LF);
            end
            ENDING_CR_TWICE:
            begin
                ending_label = "two carriage returns";
                render_line(1'b1);
                line_text.insert(line_text.size() - 1, ihex_pkg::CHAR_CR);
            end
            ENDING_CR_THEN_CHAR:
            begin
                ending_label = "a character after a carriage return";
                render_line(1'b1);
                line_text[line_text.size() - 1] = stray_char(1'b1);
            end
            ENDING_NO_COLON:
            begin
                ending_label = "a line without its colon";
                line_text[0] = stray_char(1'b1);
            end
            default:
            begin
                ending_label = "data running past the top of the address space";
                make_record(top_margin + $urandom_range(1, 3), 16'(next_addr),
                            ihex_pkg::REC_DATA);
                render_line(1'($urandom_range(0, 1)));
            end
        endcase
        send_text();
        if (ending == ENDING_STREAM_CUT)
        begin
            t.ch_value = 8'($urandom_range(0, 255));
            t.end_mark = 1'b1;
            hex_text.push_back(t);
        end

        // trailing requests that a finished parser must ignore
        t.ch_value = 8'hFF;
        t.end_mark = 1'b0;
        hex_text.push_back(t);
        t.ch_value = 8'h00;
        t.end_mark = 1'b1;
        hex_text.push_back(t);
        repeat (22)
        begin
            t.ch_value = 8'($urandom_range(0, 255));
            t.end_mark = 1'($urandom_range(0, 1));
            hex_text.push_back(t);
        end
        total_chars = hex_text.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // wait for every request to be taken and every report to arrive
        while (chars_accepted != total_chars)
            @(posedge clk);
        while (parser_reports.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("Streamed %0d characters in %0d data records from 0x%04h, closed by %s.",
                 total_chars, record_sizes.size(), start_addr[15:0], ending_label);
        $display("Checked %0d reports, %0d of them data bytes, with %0d mismatches.",
                 reports_checked, bytes_checked, mismatches);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
